>>> src/three_axis_tustin_lowpass_defines.svh
// Assertion macros shared by the checker of the three-axis Tustin lowpass.
`ifndef THREE_AXIS_TUSTIN_LOWPASS_DEFINES_SVH
`define THREE_AXIS_TUSTIN_LOWPASS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tlp_pkg.sv
// Shared constants, types and state encodings for the three-axis Tustin lowpass.
package tlp_pkg;

  // Field widths and fixed-point formats.
  localparam int SAMPLE_W = 24;
  localparam int COEF_F   = 18;
  localparam int TS_W     = 20;
  localparam int CUT_W    = 16;
  localparam int AXES     = 3;

  // Derived datapath widths.
  localparam int P_W    = TS_W + CUT_W;
  localparam int DEN_W  = P_W + 1;
  localparam int NUM_W  = P_W + COEF_F + 1;
  localparam int Q_W    = COEF_F + 1;
  localparam int A_W    = COEF_F + 2;
  localparam int SUM_W  = SAMPLE_W + 1;
  localparam int ACC_W  = SAMPLE_W + COEF_F + 3;
  localparam int DCNT_W = $clog2(Q_W);
  localparam int CNT_W  = $clog2((A_W > CUT_W) ? A_W : CUT_W) + 1;

  localparam logic [CUT_W-1:0] CUT_RESET    = CUT_W'(2560);
  // Two times 2^8 times 10^6: scales the Q8.8 rad/s times microseconds product.
  localparam logic [DEN_W-1:0] TUSTIN_SCALE = DEN_W'(512000000);

  // Main sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FILT,
    ST_OUT
  } tlp_state_t;

  // Divider sequencer states.
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_DEN,
    DV_LOAD,
    DV_RUN,
    DV_DONE
  } tlp_div_state_t;

  // Status returned by the divider.
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } tlp_div_rsp_t;

endpackage

>>> src/tlp_div.sv
// Bit-serial restoring divider that forms the Tustin coefficient B from the rate product.
module tlp_div import tlp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [P_W-1:0] prod,
  output tlp_div_rsp_t   rsp
);

  tlp_div_state_t      state_r, state_nxt;
  logic [P_W-1:0]      p_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic [Q_W-1:0]      lo_r;
  logic [Q_W-1:0]      q_r;
  logic [DCNT_W-1:0]   cnt_r;
  logic                den_en, load_en, run_en, done;
  logic [NUM_W-1:0]    num;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;
  logic                qbit;

  // Next state: form the denominator, load the numerator, then one quotient bit a cycle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (start) state_nxt = DV_DEN;
      DV_DEN:  state_nxt = DV_LOAD;
      DV_LOAD: state_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == DCNT_W'(Q_W - 1)) state_nxt = DV_DONE;
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  // Step enables decoded from the state.
  always_comb begin
    den_en  = 1'b0;
    load_en = 1'b0;
    run_en  = 1'b0;
    done    = 1'b0;
    case (state_r)
      DV_DEN:  den_en  = 1'b1;
      DV_LOAD: load_en = 1'b1;
      DV_RUN:  run_en  = 1'b1;
      DV_DONE: done    = 1'b1;
      default: ;
    endcase
  end

  // Numerator p * 2^F + D/2 for rounding to nearest, and one restoring trial step.
  always_comb begin
    num   = NUM_W'({p_r, {COEF_F{1'b0}}}) + NUM_W'(den_r >> 1);
    trial = {rem_r, lo_r[Q_W-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_en) begin
        cnt_r <= '0;
      end else if (run_en) begin
        cnt_r <= cnt_r + DCNT_W'(1);
      end
    end
  end

  // Datapath registers. The quotient is known to stay below 2^Q_W, so the
  // upper numerator bits start below the denominator.
  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && start) begin
      p_r <= prod;
    end
    if (den_en) begin
      den_r <= TUSTIN_SCALE + DEN_W'(p_r);
    end
    if (load_en) begin
      rem_r <= DEN_W'(num[NUM_W-1:Q_W]);
      lo_r  <= num[Q_W-1:0];
      q_r   <= '0;
    end else if (run_en) begin
      rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[Q_W-2:0], qbit};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q_r;

endmodule

>>> src/three_axis_tustin_lowpass.sv
// Each accepted request goes through the bit-serial rate multiplier, the restoring divider
// and the shared filter pass; a new request is taken only after the previous one is through
// all three and its result has been loaded into the output register.
// A new request is taken while the previous result still waits on the output.
// Reset (synchronous, rst_n low) clears the previous inputs and outputs to zero
// and loads the cutoff register with 10.0 rad/s.
module three_axis_tustin_lowpass import tlp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CUT_W-1:0]           cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [TS_W-1:0]            in_timestep_us,
  input  logic signed [SAMPLE_W-1:0] in_sample_x,
  input  logic signed [SAMPLE_W-1:0] in_sample_y,
  input  logic signed [SAMPLE_W-1:0] in_sample_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_filtered_x,
  output logic signed [SAMPLE_W-1:0] out_filtered_y,
  output logic signed [SAMPLE_W-1:0] out_filtered_z
);

  // Rounds away the coefficient fraction (the half is preloaded) and clamps to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    logic                    ovf;
    sh  = v >>> COEF_F;
    ovf = (sh[ACC_W-1:SAMPLE_W-1] != {(ACC_W - SAMPLE_W + 1){sh[ACC_W-1]}});
    if (ovf) begin
      return sh[ACC_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
    return sh[SAMPLE_W-1:0];
  endfunction

  tlp_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CUT_W-1:0]        cutoff_r;
  logic [CUT_W-1:0]        cut_sh_r;
  logic [P_W-1:0]          tsm_r;
  logic [P_W-1:0]          p_r;
  logic [A_W-1:0]          a_sh_r;
  logic [A_W-1:0]          b_sh_r;
  logic [A_W-1:0]          a_val;
  logic signed [SAMPLE_W-1:0] in_x      [AXES];
  logic signed [SAMPLE_W-1:0] xin_r     [AXES];
  logic signed [SAMPLE_W-1:0] xp_r      [AXES];
  logic signed [SAMPLE_W-1:0] yp_r      [AXES];
  logic signed [SAMPLE_W-1:0] out_y_r   [AXES];
  logic signed [SAMPLE_W-1:0] y_sat     [AXES];
  logic signed [SUM_W-1:0]    pair_sum  [AXES];
  logic signed [ACC_W-1:0]    ym_r      [AXES];
  logic signed [ACC_W-1:0]    sm_r      [AXES];
  logic signed [ACC_W-1:0]    acc_r     [AXES];
  logic signed [ACC_W-1:0]    acc_nxt   [AXES];
  logic signed [ACC_W-1:0]    term_a    [AXES];
  logic signed [ACC_W-1:0]    term_b    [AXES];
  logic                    out_valid_r;
  logic                    accept, mul_en, div_start, coef_load, filt_en, out_load;
  logic                    out_free, mul_last, filt_last;
  tlp_div_rsp_t            div_rsp;

  assign in_x[0] = in_sample_x;
  assign in_x[1] = in_sample_y;
  assign in_x[2] = in_sample_z;

  assign out_free  = !out_valid_r || out_ready;
  assign mul_last  = (cnt_r == CNT_W'(CUT_W - 1));
  assign filt_last = (cnt_r == CNT_W'(A_W - 1));

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL;
      ST_MUL:    if (mul_last) state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (div_rsp.done) state_nxt = ST_FILT;
      ST_FILT:   if (filt_last) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Step enables decoded from the state.
  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    coef_load = 1'b0;
    filt_en   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready  = 1'b1;
      ST_MUL:    mul_en    = 1'b1;
      ST_DSTART: div_start = 1'b1;
      ST_DIV:    coef_load = div_rsp.done;
      ST_FILT:   filt_en   = 1'b1;
      ST_OUT:    out_load  = out_free;
      default:   ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Coefficient divider.
  tlp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .prod  (p_r),
    .rsp   (div_rsp)
  );

  // A = 1 - 2B in Q1.F, two's complement.
  assign a_val = (A_W'(1) << COEF_F) - (A_W'(div_rsp.quot) << 1);

  // Filter lanes: one coefficient bit a cycle; the sign bit of A weighs negative.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pair_sum[i] = SUM_W'(xin_r[i]) + SUM_W'(xp_r[i]);
      term_a[i]   = a_sh_r[0] ? ym_r[i] : '0;
      term_b[i]   = b_sh_r[0] ? sm_r[i] : '0;
      acc_nxt[i]  = (filt_last ? acc_r[i] - term_a[i] : acc_r[i] + term_a[i]) + term_b[i];
      y_sat[i]    = sat_sample(acc_r[i]);
    end
  end

  // Control registers and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cutoff_r    <= CUT_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        xp_r[i] <= '0;
        yp_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cutoff_r <= cfg_wr_data;
      end
      if (accept || coef_load) begin
        cnt_r <= '0;
      end else if (mul_en || filt_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        for (int i = 0; i < AXES; i++) begin
          xp_r[i] <= xin_r[i];
          yp_r[i] <= y_sat[i];
        end
      end
    end
  end

  // Rate product timestep * cutoff, one cutoff bit a cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r      <= '0;
      cut_sh_r <= cutoff_r;
      tsm_r    <= P_W'(in_timestep_us);
    end else if (mul_en) begin
      if (cut_sh_r[0]) begin
        p_r <= p_r + tsm_r;
      end
      cut_sh_r <= cut_sh_r >> 1;
      tsm_r    <= tsm_r << 1;
    end
  end

  // Sample capture, filter shift registers and the output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < AXES; i++) begin
        xin_r[i] <= in_x[i];
      end
    end
    if (coef_load) begin
      a_sh_r <= a_val;
      b_sh_r <= A_W'(div_rsp.quot);
      for (int i = 0; i < AXES; i++) begin
        acc_r[i] <= ACC_W'(1) <<< (COEF_F - 1);
        ym_r[i]  <= ACC_W'(yp_r[i]);
        sm_r[i]  <= ACC_W'(pair_sum[i]);
      end
    end else if (filt_en) begin
      a_sh_r <= a_sh_r >> 1;
      b_sh_r <= b_sh_r >> 1;
      for (int i = 0; i < AXES; i++) begin
        acc_r[i] <= acc_nxt[i];
        ym_r[i]  <= ym_r[i] <<< 1;
        sm_r[i]  <= sm_r[i] <<< 1;
      end
    end
    if (out_load) begin
      for (int i = 0; i < AXES; i++) begin
        out_y_r[i] <= y_sat[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filtered_x = out_y_r[0];
  assign out_filtered_y = out_y_r[1];
  assign out_filtered_z = out_y_r[2];

endmodule

>>> src/tlp_checker.sv
// Port-level checker for the three-axis Tustin lowpass, with its bind.
`include "three_axis_tustin_lowpass_defines.svh"

module tlp_checker import tlp_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_wr_en,
  input logic [CUT_W-1:0]           cfg_wr_data,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [TS_W-1:0]            in_timestep_us,
  input logic signed [SAMPLE_W-1:0] in_sample_x,
  input logic signed [SAMPLE_W-1:0] in_sample_y,
  input logic signed [SAMPLE_W-1:0] in_sample_z,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_filtered_x,
  input logic signed [SAMPLE_W-1:0] out_filtered_y,
  input logic signed [SAMPLE_W-1:0] out_filtered_z
);

  // A stalled result keeps its value.
  `TLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_filtered_x) && $stable(out_filtered_y) && $stable(out_filtered_z), "stalled result changed")

  // Once a request is taken the block is busy with it.
  `TLP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after a request")

  // A request cannot produce its result in the very next cycle.
  `TLP_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result appeared right after a request")

  // A new result comes together with the return to idle.
  `TLP_ASSERT_NOW(a_result_frees_input, $rose(out_valid), in_ready, "result shown while still busy")

endmodule

bind three_axis_tustin_lowpass tlp_checker u_tlp_checker (.*);
